// ===== rtl/core/btrf_pkg.sv =====
// btrf_pkg: constants, widths and controller/datapath interface types
// for the bus telegram receive framer; no dependencies

package btrf_pkg;

  // buffer size and telegram framing constants
  localparam int BUFFER_BYTES = 32;
  localparam int BYTE_W       = 8;
  localparam int HEADER_BYTES = 6;
  localparam int MIN_LENGTH   = 8;
  localparam int LEN_EXTRA    = 2;   // length field plus one, plus checksum

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hBC;
  localparam logic [BYTE_W-1:0] LEN_MASK   = 8'h0F;

  // field widths
  localparam int POS_W = 5;
  localparam int LEN_W = 5;
  localparam int PTR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam int OUT_TDATA_W = ((BYTE_W + POS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FILL,
    ST_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic wr;     // store the input byte and count it
    logic clr;    // drop the buffer contents
    logic step;   // advance the drain pointer
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_hit;  // input byte is the start byte
    logic full;       // no room for another byte
    logic hdr_now;    // this byte completes the header
    logic len_bad;    // length from the header does not fit
    logic done_now;   // this byte completes the telegram
    logic last;       // drain pointer is on the final byte
  } stat_t;

endpackage

// ===== rtl/core/btrf_datapath.sv =====
// btrf_datapath: frame buffer, fill and length counters, drain pointer
// depends on btrf_pkg

module btrf_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [btrf_pkg::BYTE_W-1:0] rx_byte,
  input  btrf_pkg::cmd_t              cmd,
  output btrf_pkg::stat_t             stat,
  output logic [btrf_pkg::BYTE_W-1:0] frame_byte,
  output logic [btrf_pkg::POS_W-1:0]  byte_position
);

  logic [btrf_pkg::BYTE_W-1:0] frame_store [btrf_pkg::BUFFER_BYTES];
  logic [btrf_pkg::BYTE_W-1:0] rd_data;

  logic [btrf_pkg::CNT_W-1:0] fill_count;
  logic [btrf_pkg::LEN_W-1:0] expected_length;
  logic [btrf_pkg::PTR_W-1:0] drain_ptr;

  logic [btrf_pkg::CNT_W-1:0] fill_inc;
  logic [btrf_pkg::LEN_W-1:0] len_new;
  logic [btrf_pkg::LEN_W-1:0] len_eff;
  logic [btrf_pkg::PTR_W-1:0] wr_addr;
  logic [btrf_pkg::PTR_W-1:0] rd_addr;
  logic                       len_known;

  assign fill_inc  = fill_count + btrf_pkg::CNT_W'(1);
  assign len_known = (expected_length != '0);
  assign wr_addr   = fill_count[btrf_pkg::PTR_W-1:0];

  // length from the low nibble of the sixth byte, which is the current input
  assign len_new = btrf_pkg::LEN_W'(btrf_pkg::HEADER_BYTES + btrf_pkg::LEN_EXTRA)
                 + btrf_pkg::LEN_W'(rx_byte & btrf_pkg::LEN_MASK);

  always_comb begin
    stat.start_hit = (rx_byte == btrf_pkg::START_BYTE);
    stat.full      = (btrf_pkg::CMP_W'(fill_count) >= btrf_pkg::CMP_W'(btrf_pkg::BUFFER_BYTES));
    stat.hdr_now   = !len_known &&
                     (btrf_pkg::CMP_W'(fill_inc) >= btrf_pkg::CMP_W'(btrf_pkg::HEADER_BYTES));
    stat.len_bad   = (btrf_pkg::CMP_W'(len_new) > btrf_pkg::CMP_W'(btrf_pkg::BUFFER_BYTES)) ||
                     (btrf_pkg::CMP_W'(len_new) < btrf_pkg::CMP_W'(btrf_pkg::MIN_LENGTH));
    len_eff        = stat.hdr_now ? len_new : expected_length;
    stat.done_now  = (len_known || stat.hdr_now) &&
                     (btrf_pkg::CMP_W'(fill_inc) >= btrf_pkg::CMP_W'(len_eff));
    stat.last      = ((btrf_pkg::CNT_W'(drain_ptr) + btrf_pkg::CNT_W'(1)) == fill_count);
  end

  // read one ahead on a step so the next byte is ready in the following cycle
  always_comb begin
    priority if (cmd.clr) begin
      rd_addr = '0;
    end else if (cmd.step) begin
      rd_addr = drain_ptr + btrf_pkg::PTR_W'(1);
    end else begin
      rd_addr = drain_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      frame_store[wr_addr] <= rx_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      expected_length <= '0;
      drain_ptr       <= '0;
    end else if (cmd.clr) begin
      fill_count      <= '0;
      expected_length <= '0;
      drain_ptr       <= '0;
    end else begin
      if (cmd.wr) begin
        fill_count <= fill_inc;
        if (stat.hdr_now) begin
          expected_length <= len_new;
        end
      end
      if (cmd.step) begin
        drain_ptr <= drain_ptr + btrf_pkg::PTR_W'(1);
      end
    end
  end

  assign frame_byte    = rd_data;
  assign byte_position = btrf_pkg::POS_W'(drain_ptr);

endmodule

// ===== rtl/core/btrf_ctrl.sv =====
// btrf_ctrl: hunt / fill / drain state machine of the framer
// depends on btrf_pkg

module btrf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  input  btrf_pkg::stat_t stat,
  output btrf_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_valid
);

  btrf_pkg::state_t state;
  btrf_pkg::state_t state_next;

  logic take;   // accepted byte belongs to a frame

  assign take = in_valid && ((state == btrf_pkg::ST_FILL) ||
                             (state == btrf_pkg::ST_HUNT && stat.start_hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btrf_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btrf_pkg::ST_HUNT, btrf_pkg::ST_FILL: begin
        if (take) begin
          priority if (stat.full || (stat.hdr_now && stat.len_bad)) begin
            state_next = btrf_pkg::ST_HUNT;
          end else if (stat.done_now) begin
            state_next = btrf_pkg::ST_DRAIN;
          end else begin
            state_next = btrf_pkg::ST_FILL;
          end
        end
      end
      btrf_pkg::ST_DRAIN: begin
        if (out_ready && stat.last) begin
          state_next = btrf_pkg::ST_HUNT;
        end
      end
      default: state_next = btrf_pkg::ST_HUNT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      btrf_pkg::ST_HUNT, btrf_pkg::ST_FILL: begin
        in_ready = 1'b1;
        if (take) begin
          priority if (stat.full || (stat.hdr_now && stat.len_bad)) begin
            cmd.clr = 1'b1;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      btrf_pkg::ST_DRAIN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clr  = stat.last;
          cmd.step = !stat.last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/bus_telegram_receive_framer.sv =====
// bus_telegram_receive_framer: top level, receive framer for standard bus telegrams
// depends on btrf_pkg, btrf_ctrl, btrf_datapath

// Receive bytes come in one per s_axis transfer. While hunting, every byte other
// than the start byte 0xBC is dropped; the start byte opens a frame and is kept as
// its first byte. Once the sixth byte is in, the telegram length is 8 plus the low
// nibble of that byte (8 to 23 bytes). A frame whose length does not fit the buffer,
// or that would overflow it, is dropped without any output. When the last byte of a
// telegram arrives, the block drains the whole telegram on m_axis, one transfer per
// byte with its position, and tlast on the checksum byte. Input bytes are never
// stalled while hunting or filling; the first output byte is valid the cycle after
// the completing input byte, and the drain then runs at one byte per cycle while
// m_axis_tready is high, from the buffer's registered read port, so s_axis_tready
// stays low until the last telegram byte is taken. The buffer has no clearing pass
// after reset: an entry is only read after it was written in the same frame.

module bus_telegram_receive_framer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [btrf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] frame_byte,
                                                           // [12:8] byte_position
  output logic                             m_axis_tlast    // last_byte
);

  btrf_pkg::cmd_t  cmd;
  btrf_pkg::stat_t stat;

  logic [btrf_pkg::BYTE_W-1:0] frame_byte;
  logic [btrf_pkg::POS_W-1:0]  byte_position;

  // control: hunt for start byte, fill buffer, drain telegram
  btrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  // buffer, counters and length decode
  btrf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (s_axis_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .frame_byte    (frame_byte),
    .byte_position (byte_position)
  );

  // pack output fields, zero fill to whole bytes
  assign m_axis_tdata = btrf_pkg::OUT_TDATA_W'({byte_position, frame_byte});
  assign m_axis_tlast = stat.last;

  // input and output never open at once
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output both active");

  // a non-final output transfer is followed by the next position
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid &&
      (m_axis_tdata[12:8] == $past(m_axis_tdata[12:8]) + 5'd1))
    else $error("drain position did not advance by one");

  // the final transfer returns the block to accepting input
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after final byte");

  // every drained telegram starts at position zero
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (m_axis_tdata[12:8] == 5'd0))
    else $error("telegram drain did not start at position zero");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for bus_telegram_receive_framer, byte stream in, telegram out
// depends on btrf_pkg and bus_telegram_receive_framer; a queue-fed driver, a predictor
// and a monitor with random stalls check every delivered telegram byte

module tb_top;

  localparam int LEN_FIELD_AT = btrf_pkg::HEADER_BYTES - 1;  // header byte whose low nibble sets length
  localparam int PAD_W        = btrf_pkg::OUT_TDATA_W - btrf_pkg::BYTE_W - btrf_pkg::POS_W;
  localparam int MAX_WAIT     = 5;
  localparam int RAND_ITEMS   = 250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [btrf_pkg::BYTE_W-1:0] data;
    logic [btrf_pkg::POS_W-1:0]  pos;
    logic                        last;
  } tel_byte_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata = '0;  // [7:0] rx_byte
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [btrf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;       // [7:0] frame_byte, [12:8] byte_position
  logic                             m_axis_tlast;       // last_byte

  bus_telegram_receive_framer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus and expectations
  logic [7:0] rx_bytes_pending[$];
  tel_byte_t  frame_bytes_due[$];
  int         rx_total  = 0;
  int         rx_taken  = 0;
  int         errors    = 0;
  int         cycles    = 0;

  // predictor state: telegram buffer, fill level, known length, in-frame flag
  logic [btrf_pkg::BYTE_W-1:0] held[btrf_pkg::BUFFER_BYTES];
  int                          stored   = 0;
  int                          tel_len  = 0;
  logic                        framing  = 1'b0;

  function automatic void drop_telegram();
    stored  = 0;
    tel_len = 0;
    framing = 1'b0;
    for (int i = 0; i < btrf_pkg::BUFFER_BYTES; i++) held[i] = '0;
  endfunction

  // fold one received byte into the predictor; a completed telegram queues all its bytes
  function automatic void absorb_rx_byte(input logic [7:0] rx);
    int        tlen;
    tel_byte_t tb;
    if (!framing && rx == btrf_pkg::START_BYTE) begin
      stored  = 0;
      tel_len = 0;
      framing = 1'b1;
    end
    if (!framing) return;
    // overflow: no room left, the whole frame goes
    if (stored >= btrf_pkg::BUFFER_BYTES) begin
      drop_telegram();
      return;
    end
    held[stored] = rx;
    stored++;
    // header complete: length is fixed from the low nibble of the last header byte
    if (tel_len == 0 && stored >= btrf_pkg::HEADER_BYTES) begin
      tlen = btrf_pkg::HEADER_BYTES + int'(held[LEN_FIELD_AT] & btrf_pkg::LEN_MASK)
           + btrf_pkg::LEN_EXTRA;
      if (tlen < btrf_pkg::MIN_LENGTH || tlen > btrf_pkg::BUFFER_BYTES) begin
        drop_telegram();
        return;
      end
      tel_len = tlen;
    end
    if (tel_len != 0 && stored >= tel_len) begin
      for (int k = 0; k < stored; k++) begin
        tb.data = held[k];
        tb.pos  = btrf_pkg::POS_W'(k);
        tb.last = (k + 1 == stored);
        frame_bytes_due.push_back(tb);
      end
      drop_telegram();
    end
  endfunction

  // random byte, occasionally the start byte so it shows up inside frames too
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 15) == 0) return btrf_pkg::START_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // line noise while hunting, kept clear of the start byte
  function automatic void add_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == btrf_pkg::START_BYTE) b = ~b;
      rx_bytes_pending.push_back(b);
    end
  endfunction

  // well-formed telegram with random content, cut short when keep < full length;
  // returns the number of bytes queued
  function automatic int add_telegram(input logic [3:0] nib, input int keep);
    int         full_len;
    int         n;
    logic [7:0] b;
    full_len = btrf_pkg::HEADER_BYTES + int'(nib) + btrf_pkg::LEN_EXTRA;
    n = (keep < full_len) ? keep : full_len;
    for (int i = 0; i < n; i++) begin
      if (i == 0) b = btrf_pkg::START_BYTE;
      else if (i == LEN_FIELD_AT) b = {4'($urandom_range(0, 15)), nib};
      else b = payload_byte();
      rx_bytes_pending.push_back(b);
    end
    return n;
  endfunction

  // driver: one item per transfer, random gap drawn for every item, with
  // occasional stretches of back-to-back items
  int   in_gap   = 0;
  logic in_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_rx_byte(s_axis_tdata);
        rx_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_pending.size() > 0) begin
          s_axis_tdata  <= rx_bytes_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 19) == 0) in_burst = ~in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare every output transfer with the oldest expected byte
  int        out_stall = 0;
  logic      out_burst = 1'b0;
  tel_byte_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected output transfer, actual data %h last %b", $time,
                   m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (m_axis_tdata[btrf_pkg::BYTE_W-1:0] !== want.data) begin
            $display("%0t: frame_byte expected %h actual %h", $time, want.data,
                     m_axis_tdata[btrf_pkg::BYTE_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[btrf_pkg::BYTE_W +: btrf_pkg::POS_W] !== want.pos) begin
            $display("%0t: byte_position expected %0d actual %0d", $time, want.pos,
                     m_axis_tdata[btrf_pkg::BYTE_W +: btrf_pkg::POS_W]);
            errors++;
          end
          if (m_axis_tdata[btrf_pkg::OUT_TDATA_W-1 -: PAD_W] !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h", $time,
                     m_axis_tdata[btrf_pkg::OUT_TDATA_W-1 -: PAD_W]);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_byte expected %b actual %b", $time, want.last, m_axis_tlast);
            errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int kind;
    logic [3:0] nib;

    drop_telegram();

    // directed: noise while hunting, all-zero and all-one bytes
    rx_bytes_pending.push_back(8'h00);
    rx_bytes_pending.push_back(8'hFF);
    rx_bytes_pending.push_back(8'h3C);
    // shortest telegram, start byte as data, high nibble set in the length byte
    rx_bytes_pending.push_back(btrf_pkg::START_BYTE);
    rx_bytes_pending.push_back(8'h00);
    rx_bytes_pending.push_back(8'hFF);
    rx_bytes_pending.push_back(btrf_pkg::START_BYTE);
    rx_bytes_pending.push_back(8'h55);
    rx_bytes_pending.push_back(8'hF0);
    rx_bytes_pending.push_back(8'hAA);
    rx_bytes_pending.push_back(8'h00);
    // two start bytes back to back: the second one is stored as data
    rx_bytes_pending.push_back(btrf_pkg::START_BYTE);
    rx_bytes_pending.push_back(btrf_pkg::START_BYTE);
    rx_bytes_pending.push_back(8'h01);
    rx_bytes_pending.push_back(8'h02);
    rx_bytes_pending.push_back(8'h03);
    rx_bytes_pending.push_back(8'h11);
    rx_bytes_pending.push_back(8'h04);
    rx_bytes_pending.push_back(8'h05);
    rx_bytes_pending.push_back(8'h06);

    // random: mostly whole telegrams, some noise and some cut-short frames;
    // the first one is the longest telegram
    void'(add_telegram(4'hF, btrf_pkg::BUFFER_BYTES));
    while (rx_bytes_pending.size() < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          add_noise($urandom_range(1, 4));
        end
        1: begin
          nib = 4'($urandom_range(0, 15));
          void'(add_telegram(nib, $urandom_range(1, btrf_pkg::HEADER_BYTES + 4)));
        end
        default: begin
          case ($urandom_range(0, 4))
            0: nib = 4'h0;
            1: nib = 4'hF;
            default: nib = 4'($urandom_range(0, 15));
          endcase
          void'(add_telegram(nib, btrf_pkg::BUFFER_BYTES));
        end
      endcase
    end
    void'(add_telegram(4'($urandom_range(0, 15)), btrf_pkg::BUFFER_BYTES));
    rx_total = rx_bytes_pending.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (rx_taken < rx_total || frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
